@@ sv/automorphism_column_permuter_unit_defines.svh @@
// assertion macros for the checker file
`ifndef AUTOMORPHISM_COLUMN_PERMUTER_UNIT_DEFINES_SVH
`define AUTOMORPHISM_COLUMN_PERMUTER_UNIT_DEFINES_SVH

// property checked on rising clock, ignored while reset is asserted
`define ACP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acp assertion failed");

// property checked on every rising clock, reset included
`define ACP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("acp assertion failed");

`endif

@@ sv/acp_pkg.sv @@
package acp_pkg;

  localparam int ROWS      = 8;
  localparam int ROW_BITS  = 3;
  localparam int COL_BITS  = 13;
  localparam int K_BITS    = 17;
  localparam int LOG_BITS  = 4;
  localparam int LANE_BITS = 64;
  localparam int JK_BITS   = COL_BITS + K_BITS;
  localparam int CFG_BITS  = 17;

  localparam logic [K_BITS-1:0]   K_RESET   = K_BITS'(1);
  localparam logic [LOG_BITS-1:0] LOG_RESET = LOG_BITS'(9);

  typedef enum logic [0:0] {
    CFG_K_EXPONENT = 1'b0,
    CFG_LOG_COLS   = 1'b1
  } cfg_addr_e;

  typedef logic [LANE_BITS-1:0] lane_t;
  typedef lane_t lane_arr_t [ROWS];

  typedef struct packed {
    cfg_addr_e           addr;
    logic [CFG_BITS-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [COL_BITS-1:0] src_column;
    lane_t               lane0_in;
    lane_t               lane1_in;
    lane_t               lane2_in;
    lane_t               lane3_in;
    lane_t               lane4_in;
    lane_t               lane5_in;
    lane_t               lane6_in;
    lane_t               lane7_in;
  } item_t;

  typedef struct packed {
    logic [COL_BITS-1:0] dst_column;
    lane_t               lane0_out;
    lane_t               lane1_out;
    lane_t               lane2_out;
    lane_t               lane3_out;
    lane_t               lane4_out;
    lane_t               lane5_out;
    lane_t               lane6_out;
    lane_t               lane7_out;
  } result_t;

  // unpack the source rows of an input transaction
  function automatic lane_arr_t item_lanes(item_t it);
    lane_arr_t l;
    l[0] = it.lane0_in;
    l[1] = it.lane1_in;
    l[2] = it.lane2_in;
    l[3] = it.lane3_in;
    l[4] = it.lane4_in;
    l[5] = it.lane5_in;
    l[6] = it.lane6_in;
    l[7] = it.lane7_in;
    return l;
  endfunction

  // pack a destination column into a result transaction
  function automatic result_t make_result(logic [COL_BITS-1:0] col, lane_arr_t l);
    result_t r;
    r.dst_column = col;
    r.lane0_out  = l[0];
    r.lane1_out  = l[1];
    r.lane2_out  = l[2];
    r.lane3_out  = l[3];
    r.lane4_out  = l[4];
    r.lane5_out  = l[5];
    r.lane6_out  = l[6];
    r.lane7_out  = l[7];
    return r;
  endfunction

endpackage

@@ sv/acp_channels.sv @@
// column input channel
interface acp_item_if import acp_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// column result channel
interface acp_result_if import acp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// register write channel
interface acp_cfg_if import acp_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/automorphism_column_permuter_unit.sv @@
// Automorphism column permuter: takes one polynomial column (index j and its eight
// 64-bit row coefficients) per transaction and returns the permuted column at
// (j*k) mod C, output row r taking input row ((r - d)*k) mod 8 with
// d = (j*k >> log_cols) mod 8. A column is accepted every cycle unless output
// back-pressure stalls the pipeline. Each column passes one input register,
// then the 13x17 j*k multiply, the log_cols shift and the eight-way 64-bit row
// crossbar feeding the result register. That multiply-shift-crossbar path sets
// the cycle time. log_cols above 13 acts as 13. The user must write registers
// k_exponent (index 0, reset 1) and log_cols (index 1, reset 9) only while no
// column is in flight, unenforced by the block. The write channel is always ready.
module automorphism_column_permuter_unit import acp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  acp_cfg_if.sink       cfg_ch,
  acp_item_if.sink      in_ch,
  acp_result_if.source  out_ch
);

  logic [K_BITS-1:0]   k_q;
  logic [LOG_BITS-1:0] log_q;

  logic                s1_valid_q, s1_valid_d;
  logic [COL_BITS-1:0] s1_col_q;
  lane_arr_t           s1_lane_q;

  logic                out_valid_q, out_valid_d;
  result_t             out_q;

  logic                in_acc;
  logic                s1_adv;
  logic [LOG_BITS-1:0] lc;
  logic [JK_BITS-1:0]  jk;
  logic [ROW_BITS-1:0] dsel;
  logic [COL_BITS:0]   col_lim;
  logic [COL_BITS-1:0] col_mask;
  logic [COL_BITS-1:0] dst_col;
  lane_arr_t           perm_lane;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= K_RESET;
      log_q <= LOG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.addr)
        CFG_K_EXPONENT: k_q   <= cfg_ch.data.wdata[K_BITS-1:0];
        CFG_LOG_COLS:   log_q <= cfg_ch.data.wdata[LOG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign s1_adv      = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= in_ch.data.src_column;
      s1_lane_q <= item_lanes(in_ch.data);
    end
  end

  // destination column and row rotation
  always_comb begin
    lc       = (log_q > LOG_BITS'(COL_BITS)) ? LOG_BITS'(COL_BITS) : log_q;
    jk       = JK_BITS'(s1_col_q) * JK_BITS'(k_q);
    dsel     = ROW_BITS'(jk >> lc);
    col_lim  = (COL_BITS+1)'(1) << lc;
    col_mask = COL_BITS'(col_lim - 1'b1);
    dst_col  = jk[COL_BITS-1:0] & col_mask;
  end

  // row crossbar
  always_comb begin
    logic [ROW_BITS-1:0] diff;
    logic [ROW_BITS-1:0] src_row;
    for (int r = 0; r < ROWS; r++) begin
      diff         = ROW_BITS'(r) - dsel;
      src_row      = ROW_BITS'(diff * k_q[ROW_BITS-1:0]);
      perm_lane[r] = s1_lane_q[src_row];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q <= make_result(dst_col, perm_lane);
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

endmodule

@@ sv/acp_checker.sv @@
`include "automorphism_column_permuter_unit_defines.svh"

module acp_checker import acp_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // no result during reset
  `ACP_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i)

  // a stalled result holds its value
  `ACP_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))

  // an empty output register never blocks the input
  `ACP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  // once an accepted column has passed the input and result registers, the output is valid
  `ACP_ASSERT(a_latency, clk_i, rst_ni, in_acc |-> ##2 out_valid_i)

endmodule

bind automorphism_column_permuter_unit acp_checker u_acp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import acp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF    = 80;

  logic clk_i;
  logic rst_ni;

  acp_cfg_if    cfg_ch ();
  acp_item_if   in_ch ();
  acp_result_if out_ch ();

  automorphism_column_permuter_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the register file
  logic [K_BITS-1:0]   k_cur   = K_RESET;
  logic [LOG_BITS-1:0] log_cur = LOG_RESET;

  result_t     pending_columns [$];
  int unsigned columns_sent    = 0;
  int unsigned columns_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_off_cycles = 0;
  bit          src_idle        = 1'b1;
  bit          sink_idle       = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // split an input column into its rows
  function automatic lane_arr_t column_rows(item_t col);
    lane_arr_t rows;
    rows[0] = col.lane0_in;
    rows[1] = col.lane1_in;
    rows[2] = col.lane2_in;
    rows[3] = col.lane3_in;
    rows[4] = col.lane4_in;
    rows[5] = col.lane5_in;
    rows[6] = col.lane6_in;
    rows[7] = col.lane7_in;
    return rows;
  endfunction

  // split a result column into its rows
  function automatic lane_arr_t result_rows(result_t res);
    lane_arr_t rows;
    rows[0] = res.lane0_out;
    rows[1] = res.lane1_out;
    rows[2] = res.lane2_out;
    rows[3] = res.lane3_out;
    rows[4] = res.lane4_out;
    rows[5] = res.lane5_out;
    rows[6] = res.lane6_out;
    rows[7] = res.lane7_out;
    return rows;
  endfunction

  // destination column and row crossbar for the current k and log_cols
  function automatic result_t permute_column(item_t col);
    lane_arr_t           src;
    lane_arr_t           dst;
    logic [JK_BITS-1:0]  jk;
    logic [LOG_BITS-1:0] lc;
    logic [2:0]          d;
    logic [2:0]          diff;
    logic [2:0]          src_row;
    result_t             res;
    src = column_rows(col);
    lc  = (log_cur > LOG_BITS'(COL_BITS)) ? LOG_BITS'(COL_BITS) : log_cur;
    jk  = JK_BITS'(col.src_column) * JK_BITS'(k_cur);
    d   = 3'(jk >> lc);
    for (int r = 0; r < ROWS; r++) begin
      diff    = 3'(r) - d;
      src_row = 3'(diff * k_cur[2:0]);
      dst[r]  = src[src_row];
    end
    res.dst_column = COL_BITS'(jk & ((JK_BITS'(1) << lc) - JK_BITS'(1)));
    res.lane0_out  = dst[0];
    res.lane1_out  = dst[1];
    res.lane2_out  = dst[2];
    res.lane3_out  = dst[3];
    res.lane4_out  = dst[4];
    res.lane5_out  = dst[5];
    res.lane6_out  = dst[6];
    res.lane7_out  = dst[7];
    return res;
  endfunction

  // follow register writes, check results, then record new expectations
  always @(posedge clk_i) begin
    result_t   want;
    lane_arr_t want_rows;
    lane_arr_t got_rows;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data.addr == CFG_K_EXPONENT) begin
          k_cur = cfg_ch.data.wdata[K_BITS-1:0];
        end else begin
          log_cur = cfg_ch.data.wdata[LOG_BITS-1:0];
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_columns.size() == 0) begin
          $error("unexpected result transaction, dst_column %0d", out_ch.data.dst_column);
          mismatches++;
        end else begin
          want = pending_columns.pop_front();
          if (out_ch.data.dst_column !== want.dst_column) begin
            $error("dst_column: expected %0d, actual %0d", want.dst_column,
                   out_ch.data.dst_column);
            mismatches++;
          end
          want_rows = result_rows(want);
          got_rows  = result_rows(out_ch.data);
          for (int r = 0; r < ROWS; r++) begin
            if (got_rows[r] !== want_rows[r]) begin
              $error("lane%0d_out: expected %h, actual %h", r, want_rows[r], got_rows[r]);
              mismatches++;
            end
          end
          columns_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_columns.push_back(permute_column(in_ch.data));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result receiver with random stalls and an optional long hold-off
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // column with random row contents
  function automatic item_t random_column(logic [COL_BITS-1:0] j);
    item_t col;
    col = $bits(item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom});
    col.src_column = j;
    return col;
  endfunction

  // column with every row set to the same value
  function automatic item_t flat_column(logic [COL_BITS-1:0] j, lane_t v);
    item_t col;
    col.src_column = j;
    col.lane0_in   = v;
    col.lane1_in   = v;
    col.lane2_in   = v;
    col.lane3_in   = v;
    col.lane4_in   = v;
    col.lane5_in   = v;
    col.lane6_in   = v;
    col.lane7_in   = v;
    return col;
  endfunction

  // offer one column and wait for its transaction; valid stays high afterwards
  task automatic send_column(item_t col);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= col;
    do @(posedge clk_i); while (!in_ch.ready);
    columns_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (columns_checked < columns_sent) @(posedge clk_i);
  endtask

  // write both registers, random junk above the log_cols field
  task automatic set_config(logic [K_BITS-1:0] k, logic [LOG_BITS-1:0] lc);
    logic [CFG_BITS-1:0] junk;
    junk = CFG_BITS'($urandom);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{addr: CFG_K_EXPONENT, wdata: k};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.data  <= '{addr: CFG_LOG_COLS, wdata: {junk[CFG_BITS-1:LOG_BITS], lc}};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // registers as left by reset
  task automatic test_reset_settings();
    send_column(flat_column('0, '0));
    send_column(flat_column(13'd511, '1));
    send_column(random_column(13'd1));
    send_column(random_column(13'd8191));
  endtask

  // extreme exponents and column counts, clamping and even k
  task automatic test_extreme_settings();
    set_config(17'd131071, 4'd13);
    send_column(random_column(13'd8191));
    send_column(flat_column('0, '1));
    send_column(random_column(13'd4097));
    set_config(17'd1, 4'd0);
    send_column(random_column('0));
    send_column(random_column(13'd8191));
    // log_cols above the maximum acts as the maximum
    set_config(17'd3, 4'd14);
    send_column(random_column(13'd5000));
    send_column(random_column(13'd8191));
    set_config(17'd131069, 4'd15);
    send_column(random_column(13'd123));
    send_column(flat_column(13'd8191, '0));
    // zero and even exponents repeat some rows
    set_config(17'd0, 4'd4);
    send_column(random_column(13'd7));
    set_config(17'd2, 4'd2);
    send_column(random_column(13'd3));
    send_column(random_column(13'd5));
    set_config(17'd131070, 4'd1);
    send_column(random_column(13'd1));
    send_column(random_column(13'd8191));
    set_config(17'd5, 4'd3);
    send_column(random_column(13'd2));
  endtask

  // random settings, mostly in-range columns
  task automatic test_random_settings();
    logic [K_BITS-1:0]   k;
    logic [LOG_BITS-1:0] lc;
    int unsigned         cols;
    logic [COL_BITS-1:0] j;
    for (int phase = 0; phase < 10; phase++) begin
      k  = K_BITS'($urandom);
      lc = LOG_BITS'($urandom_range(0, 15));
      if (phase % 4 != 3) k[0] = 1'b1;
      set_config(k, lc);
      src_idle  = (phase != 2) && ($urandom_range(0, 3) != 0);
      sink_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
      cols = 1 << ((lc > COL_BITS) ? COL_BITS : lc);
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          j = COL_BITS'($urandom_range(0, cols - 1));
        end else begin
          j = COL_BITS'($urandom);
        end
        send_column(random_column(j));
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // long receiver hold-off with a back-to-back sender, then a drained pause
  task automatic test_backpressure();
    set_config(17'd131071, 4'd13);
    src_idle        = 1'b0;
    sink_idle       = 1'b0;
    hold_off_cycles = HOLD_OFF;
    for (int n = 0; n < 40; n++) send_column(random_column(COL_BITS'($urandom)));
    wait_drained();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int n = 0; n < 40; n++) send_column(random_column(COL_BITS'($urandom)));
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_extreme_settings();
    test_random_settings();
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_columns.size() != 0) begin
      $error("%0d result transactions never arrived", pending_columns.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
